// ===== rtl/tmb_pkg.sv =====
`timescale 1ns / 1ps
// tmb_pkg: shared types and constants for the countdown timer bank
// no dependencies

package tmb_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_ONESHOT  = 2'd0;
    localparam t_kind KIND_MULTI    = 2'd1;
    localparam t_kind KIND_PERIODIC = 2'd2;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned HANDLE_W = 3;
    localparam int unsigned MASK_W   = 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic do_add;
        logic do_presc;
        logic walk_clr;
        logic walk_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic tick_due;
        logic walk_last;
        logic out_busy;
    } t_status;

endpackage

// ===== rtl/tmb_ctrl.sv =====
`timescale 1ns / 1ps
// tmb_ctrl: sequencing state machine for the timer bank
// depends on tmb_pkg

module tmb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tmb_pkg::t_status i_status,
    output tmb_pkg::t_cmd   o_cmd
);
    import tmb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_status.mode) begin
                    o_cmd.do_add = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.do_presc = 1'b1;
                    if (i_status.tick_due) begin
                        o_cmd.walk_clr = 1'b1;
                        n_state        = S_WALK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/tmb_dpath.sv =====
`timescale 1ns / 1ps
// tmb_dpath: slot storage, prescaler, slot walk and result register
// depends on tmb_pkg

module tmb_dpath #(
    parameter int unsigned TIMER_COUNT = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tmb_pkg::t_cmd                   i_cmd,
    output tmb_pkg::t_status                o_status,
    input  logic                            i_cfg_we,
    input  logic [tmb_pkg::DATA_W-1:0]      i_cfg_wdata,
    input  logic                            i_mode,
    input  logic [tmb_pkg::DATA_W-1:0]      i_period_ticks,
    input  tmb_pkg::t_kind                  i_timer_kind,
    input  logic [tmb_pkg::DATA_W-1:0]      i_shot_limit,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_add_ok,
    output logic [tmb_pkg::HANDLE_W-1:0]    o_handle,
    output logic [tmb_pkg::MASK_W-1:0]      o_fired_mask,
    output logic [tmb_pkg::MASK_W-1:0]      o_active_mask
);
    import tmb_pkg::*;

    localparam int unsigned IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    // configuration and prescaler
    logic [DATA_W-1:0] r_res;
    logic [DATA_W-1:0] r_presc;
    logic [DATA_W-1:0] w_res_eff;
    logic [DATA_W-1:0] w_presc_inc;
    logic              w_tick_due;

    // captured input beat
    logic              r_mode;
    logic [DATA_W-1:0] r_in_period;
    t_kind             r_in_kind;
    logic [DATA_W-1:0] r_in_limit;

    // slot storage
    logic [TIMER_COUNT-1:0] r_active;
    t_kind                  r_kind   [TIMER_COUNT];
    logic [DATA_W-1:0]      r_period [TIMER_COUNT];
    logic [DATA_W-1:0]      r_rem    [TIMER_COUNT];
    logic [DATA_W-1:0]      r_limit  [TIMER_COUNT];
    logic [DATA_W-1:0]      r_shots  [TIMER_COUNT];

    // walk and result
    logic [IW-1:0]       r_idx;
    logic [MASK_W-1:0]   r_fired;
    logic                r_res_ok;
    logic [HANDLE_W-1:0] r_res_handle;

    logic                r_out_valid;
    logic                r_out_ok;
    logic [HANDLE_W-1:0] r_out_handle;
    logic [MASK_W-1:0]   r_out_fired;
    logic [MASK_W-1:0]   r_out_active;

    logic [IW-1:0]       w_free_idx;
    logic                w_any_free;
    logic [HANDLE_W-1:0] w_free_handle;
    logic [DATA_W-1:0]   w_add_period;
    logic [MASK_W-1:0]   w_active_mask;

    logic [DATA_W-1:0]   w_cur_rem;
    logic [DATA_W-1:0]   w_cur_shots;
    logic [DATA_W-1:0]   w_shots_inc;
    logic                w_fire;
    logic [DATA_W-1:0]   w_new_rem;
    logic [DATA_W-1:0]   w_new_shots;
    logic                w_new_active;
    logic [MASK_W-1:0]   w_fire_bit;

    assign w_res_eff   = (r_res == '0) ? DATA_W'(1) : r_res;
    assign w_presc_inc = r_presc + DATA_W'(1);
    assign w_tick_due  = (w_presc_inc >= w_res_eff);

    // lowest free slot
    always_comb begin
        w_any_free = 1'b0;
        w_free_idx = '0;
        for (int i = TIMER_COUNT - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_any_free = 1'b1;
                w_free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        w_free_handle = '0;
        for (int b = 0; b < HANDLE_W; b++) begin
            if (b < IW) begin
                w_free_handle[b] = w_free_idx[b];
            end
        end
    end

    always_comb begin
        w_active_mask = '0;
        w_fire_bit    = '0;
        for (int b = 0; b < MASK_W; b++) begin
            if (b < TIMER_COUNT) begin
                w_active_mask[b] = r_active[b];
                w_fire_bit[b]    = (r_idx == IW'(b));
            end
        end
    end

    assign w_add_period = (r_in_period == '0) ? DATA_W'(1) : r_in_period;

    // one slot of the countdown walk
    assign w_cur_rem   = r_rem[r_idx];
    assign w_cur_shots = r_shots[r_idx];
    assign w_shots_inc = w_cur_shots + DATA_W'(1);
    assign w_fire      = (w_cur_rem <= DATA_W'(1));

    always_comb begin
        w_new_rem    = w_cur_rem - DATA_W'(1);
        w_new_shots  = w_cur_shots;
        w_new_active = 1'b1;
        if (w_fire) begin
            w_new_shots = w_shots_inc;
            case (r_kind[r_idx])
                KIND_PERIODIC: begin
                    w_new_rem = r_period[r_idx];
                end
                KIND_MULTI: begin
                    if (w_shots_inc >= r_limit[r_idx]) begin
                        w_new_rem    = '0;
                        w_new_active = 1'b0;
                    end else begin
                        w_new_rem = r_period[r_idx];
                    end
                end
                default: begin
                    w_new_rem    = '0;
                    w_new_active = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res   <= DATA_W'(1);
            r_presc <= '0;
        end else begin
            if (i_cfg_we) begin
                r_res <= i_cfg_wdata;
            end
            if (i_cmd.do_presc) begin
                r_presc <= w_tick_due ? '0 : w_presc_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode      <= i_mode;
            r_in_period <= i_period_ticks;
            r_in_kind   <= i_timer_kind;
            r_in_limit  <= i_shot_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cmd.do_add && w_any_free) begin
            r_active[w_free_idx] <= 1'b1;
        end else if (i_cmd.walk_step && r_active[r_idx]) begin
            r_active[r_idx] <= w_new_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_add && w_any_free) begin
            r_kind[w_free_idx]   <= r_in_kind;
            r_period[w_free_idx] <= w_add_period;
            r_rem[w_free_idx]    <= w_add_period;
            r_limit[w_free_idx]  <= r_in_limit;
            r_shots[w_free_idx]  <= '0;
        end else if (i_cmd.walk_step && r_active[r_idx]) begin
            r_rem[r_idx]   <= w_new_rem;
            r_shots[r_idx] <= w_new_shots;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_fired      <= '0;
            r_res_ok     <= 1'b0;
            r_res_handle <= '0;
        end else if (i_cmd.do_add && w_any_free) begin
            r_res_ok     <= 1'b1;
            r_res_handle <= w_free_handle;
        end else if (i_cmd.walk_step && r_active[r_idx] && w_fire) begin
            r_fired <= r_fired | w_fire_bit;
        end
        if (i_cmd.walk_clr) begin
            r_idx <= '0;
        end else if (i_cmd.walk_step) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_ok     <= r_res_ok;
            r_out_handle <= r_res_handle;
            r_out_fired  <= r_fired;
            r_out_active <= w_active_mask;
        end
    end

    assign o_status.mode      = r_mode;
    assign o_status.tick_due  = w_tick_due;
    assign o_status.walk_last = (r_idx == IW'(TIMER_COUNT - 1));
    assign o_status.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_add_ok      = r_out_ok;
    assign o_handle      = r_out_handle;
    assign o_fired_mask  = r_out_fired;
    assign o_active_mask = r_out_active;

    // a successful add leaves its slot active
    a_add_claims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_add && w_any_free) |=> r_active[$past(w_free_idx)])
        else $error("added slot not active");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while stalled");

    // the slot walk only runs for raw tick beats
    a_walk_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk_clr || i_cmd.walk_step) |-> r_mode)
        else $error("walk on add beat");

    // adds never touch the prescaler
    a_add_no_presc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_add |=> $stable(r_presc))
        else $error("prescaler moved on add");

endmodule

// ===== rtl/multi_mode_countdown_timer_bank_top.sv =====
`timescale 1ns / 1ps
// multi_mode_countdown_timer_bank_top: bank of countdown timers behind a prescaler
// depends on tmb_pkg, tmb_ctrl, tmb_dpath
//
// input channel i_in_valid / o_in_ready carries one beat per item: mode 0 adds a
// timer (period, kind, shot limit), mode 1 is one raw tick for the prescaler.
// output channel o_out_valid / i_out_ready returns one result beat per item:
// add status, handle, fired slots and active slots after the item.
// i_cfg_we / i_cfg_wdata write the raw ticks per timer tick; the user must write
// them only while idle, as the block does not enforce it. each beat goes from
// decode to the done state, which loads the result register; a raw tick that makes
// a timer tick first runs the slot walk, which visits one slot per cycle.
// the next beat is accepted once the controller is back in idle after the result
// is loaded, so the bank takes no new item before the last result is loaded.
// a result waits in its output register while the receiver stalls; the next
// item is accepted meanwhile and its result is held until the register frees.
// reset clears all slots to inactive, the prescaler count to zero and the
// resolution to one; no clearing pass is needed.

module multi_mode_countdown_timer_bank_top #(
    parameter int unsigned TIMER_COUNT = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tmb_pkg::DATA_W-1:0]      i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_mode,
    input  logic [tmb_pkg::DATA_W-1:0]      i_period_ticks,
    input  tmb_pkg::t_kind                  i_timer_kind,
    input  logic [tmb_pkg::DATA_W-1:0]      i_shot_limit,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_add_ok,
    output logic [tmb_pkg::HANDLE_W-1:0]    o_handle,
    output logic [tmb_pkg::MASK_W-1:0]      o_fired_mask,
    output logic [tmb_pkg::MASK_W-1:0]      o_active_mask
);
    import tmb_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    tmb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tmb_dpath #(
        .TIMER_COUNT (TIMER_COUNT)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_mode         (i_mode),
        .i_period_ticks (i_period_ticks),
        .i_timer_kind   (i_timer_kind),
        .i_shot_limit   (i_shot_limit),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_add_ok       (o_add_ok),
        .o_handle       (o_handle),
        .o_fired_mask   (o_fired_mask),
        .o_active_mask  (o_active_mask)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for multi_mode_countdown_timer_bank_top
// depends on tmb_pkg and the timer bank rtl; carries its own timer bank predictor and scoreboard

package tb_timer_pkg;

    import tmb_pkg::*;

    localparam logic  MODE_ADD    = 1'b0;
    localparam logic  MODE_TICK   = 1'b1;
    localparam t_kind KIND_UNUSED = 2'd3;
    localparam int    NUM_SLOTS   = 8;

    typedef struct packed {
        logic                mode;
        logic [DATA_W-1:0]   period;
        t_kind               kind;
        logic [DATA_W-1:0]   limit;
    } t_timer_req;

    typedef struct packed {
        logic                add_ok;
        logic [HANDLE_W-1:0] handle;
        logic [MASK_W-1:0]   fired;
        logic [MASK_W-1:0]   active;
    } t_timer_resp;

    class t_timer_bank_scoreboard;
        bit [DATA_W-1:0] resolution;
        bit [DATA_W-1:0] prescale;
        bit              active[NUM_SLOTS];
        t_kind           kind[NUM_SLOTS];
        bit [DATA_W-1:0] period[NUM_SLOTS];
        bit [DATA_W-1:0] remaining[NUM_SLOTS];
        bit [DATA_W-1:0] limit[NUM_SLOTS];
        bit [DATA_W-1:0] shots[NUM_SLOTS];
        t_timer_resp     expected_q[$];
        int              errors;

        function new();
            resolution = 1;
            prescale = 0;
            errors = 0;
            foreach (active[s]) active[s] = 1'b0;
        endfunction

        function void set_resolution(bit [DATA_W-1:0] value);
            resolution = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // slots that will not expire any time soon
        function int long_lived();
            int n;
            n = 0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                if (active[s] && (kind[s] == KIND_PERIODIC || remaining[s] > 64 ||
                    (kind[s] == KIND_MULTI && limit[s] > shots[s] + 16)))
                    n++;
            end
            return n;
        endfunction

        function bit [MASK_W-1:0] active_bits();
            bit [MASK_W-1:0] m;
            m = '0;
            for (int s = 0; s < NUM_SLOTS && s < MASK_W; s++) m[s] = active[s];
            return m;
        endfunction

        function bit [MASK_W-1:0] count_down();
            bit [MASK_W-1:0] fired;
            fired = '0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                if (!active[s]) continue;
                if (remaining[s] > 1) begin
                    remaining[s]--;
                    continue;
                end
                remaining[s] = 0;
                if (s < MASK_W) fired[s] = 1'b1;
                shots[s]++;
                if (kind[s] == KIND_PERIODIC) begin
                    remaining[s] = period[s];
                end else if (kind[s] == KIND_MULTI && shots[s] < limit[s]) begin
                    remaining[s] = period[s];
                end else begin
                    active[s] = 1'b0;
                end
            end
            return fired;
        endfunction

        function void note_request(t_timer_req req);
            t_timer_resp r;
            bit [DATA_W-1:0] res;
            r = '0;
            if (req.mode == MODE_ADD) begin
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (!active[s]) begin
                        period[s] = (req.period == 0) ? 1 : req.period;
                        remaining[s] = period[s];
                        kind[s] = req.kind;
                        limit[s] = req.limit;
                        shots[s] = 0;
                        active[s] = 1'b1;
                        r.add_ok = 1'b1;
                        r.handle = HANDLE_W'(s);
                        break;
                    end
                end
            end else begin
                res = (resolution == 0) ? 1 : resolution;
                prescale++;
                if (prescale >= res) begin
                    prescale = 0;
                    r.fired = count_down();
                end
            end
            r.active = active_bits();
            expected_q.push_back(r);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_response(t_timer_resp got);
            t_timer_resp want;
            if (expected_q.size() == 0) begin
                $display("%0t: result beat mismatch, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.add_ok !== want.add_ok)
                report("add_ok", 32'(want.add_ok), 32'(got.add_ok));
            if (got.handle !== want.handle)
                report("handle", 32'(want.handle), 32'(got.handle));
            if (got.fired !== want.fired)
                report("fired_mask", 32'(want.fired), 32'(got.fired));
            if (got.active !== want.active)
                report("active_mask", 32'(want.active), 32'(got.active));
        endfunction
    endclass

endpackage

module tb;

    import tmb_pkg::*;
    import tb_timer_pkg::*;

    localparam int LIMIT = 400000;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                cfg_we     = 1'b0;
    logic [DATA_W-1:0]   cfg_wdata  = '0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic                mode       = MODE_TICK;
    logic [DATA_W-1:0]   period     = '0;
    t_kind               kind       = KIND_ONESHOT;
    logic [DATA_W-1:0]   limit      = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic                add_ok;
    logic [HANDLE_W-1:0] handle;
    logic [MASK_W-1:0]   fired_mask;
    logic [MASK_W-1:0]   active_mask;

    t_timer_bank_scoreboard model;
    int cycles     = 0;
    int burst_left = 0;
    bit hold_req   = 1'b0;

    multi_mode_countdown_timer_bank_top #(
        .TIMER_COUNT(NUM_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_mode         (mode),
        .i_period_ticks (period),
        .i_timer_kind   (kind),
        .i_shot_limit   (limit),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_add_ok       (add_ok),
        .o_handle       (handle),
        .o_fired_mask   (fired_mask),
        .o_active_mask  (active_mask)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // result side: checks every beat, stalls on its own pattern and on a hold requested by the stimulus
    initial begin
        int hold_left;
        int rx_cycles;
        t_timer_resp got;
        hold_left = 0;
        rx_cycles = 0;
        forever begin
            @(posedge i_clk);
            rx_cycles++;
            if (out_valid && out_ready) begin
                got = '{add_ok, handle, fired_mask, active_mask};
                model.check_response(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
                out_ready <= 1'b0;
            end else begin
                case ((rx_cycles / 97) % 4)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(1) == 1);
                    2: out_ready <= ((rx_cycles % 5) == 0);
                    default: out_ready <= ($urandom_range(9) != 0);
                endcase
            end
        end
    end

    task automatic send_request(input t_timer_req req);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(120, 60)
                                                  : $urandom_range(12, 1);
            gap = $urandom_range(10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        mode     <= req.mode;
        period   <= req.period;
        kind     <= req.kind;
        limit    <= req.limit;
        do @(posedge i_clk); while (!in_ready);
        model.note_request(req);
    endtask

    task automatic add_timer(input logic [DATA_W-1:0] p, input t_kind k,
                             input logic [DATA_W-1:0] l);
        send_request('{MODE_ADD, p, k, l});
    endtask

    task automatic raw_tick();
        send_request('{MODE_TICK, DATA_W'($urandom), t_kind'($urandom), DATA_W'($urandom)});
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        repeat (NUM_SLOTS + 4) @(posedge i_clk);
    endtask

    task automatic write_resolution(input logic [DATA_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        model.set_resolution(value);
    endtask

    function automatic t_timer_req random_request();
        t_timer_req req;
        int tick_pct;
        tick_pct = (model.resolution > 2) ? 85 : 55;
        req.mode   = ($urandom_range(99) < tick_pct) ? MODE_TICK : MODE_ADD;
        req.period = $urandom;
        req.kind   = t_kind'($urandom_range(3));
        req.limit  = $urandom;
        if (req.mode == MODE_ADD) begin
            if (model.long_lived() < 5 && $urandom_range(7) == 0) begin
                case ($urandom_range(2))
                    0: begin
                        req.kind   = KIND_PERIODIC;
                        req.period = $urandom_range(12);
                    end
                    1: begin
                        req.kind   = KIND_MULTI;
                        req.period = $urandom_range(4);
                    end
                    default: req.period = $urandom | 32'h100;
                endcase
            end else begin
                req.period = $urandom_range(8);
                if (req.kind == KIND_PERIODIC) req.kind = KIND_ONESHOT;
                if (req.kind == KIND_MULTI) req.limit = $urandom_range(5);
            end
        end
        return req;
    endfunction

    initial begin
        logic [DATA_W-1:0] phase_res[6];
        int                phase_len[6];
        phase_res = '{32'd0, 32'd3, 32'hFFFF_FFFF, 32'd2, 32'd7, 32'd1};
        phase_len = '{180, 180, 40, 180, 180, 180};
        model = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tick on an empty bank, then every kind and the period extremes
        raw_tick();
        add_timer(32'd0, KIND_ONESHOT, 32'hFFFF_FFFF);
        add_timer(32'd1, KIND_MULTI, 32'd0);
        add_timer(32'd2, KIND_MULTI, 32'd3);
        add_timer(32'd3, KIND_PERIODIC, 32'd0);
        add_timer(32'd2, KIND_UNUSED, 32'hA5A5_A5A5);
        add_timer(32'hFFFF_FFFF, KIND_ONESHOT, 32'd0);
        add_timer(32'd5, KIND_MULTI, 32'd1);
        add_timer(32'hFFFF_FFFF, KIND_PERIODIC, 32'hFFFF_FFFF);
        // bank full
        add_timer(32'd4, KIND_MULTI, 32'd2);
        repeat (8) raw_tick();
        add_timer(32'd1, KIND_ONESHOT, 32'h5A5A_5A5A);
        raw_tick();

        // resolution lowered below the running count
        write_resolution(32'd5);
        repeat (3) raw_tick();
        write_resolution(32'd2);
        raw_tick();

        for (int ph = 0; ph < 6; ph++) begin
            write_resolution(phase_res[ph]);
            for (int n = 0; n < phase_len[ph]; n++) begin
                if (n == phase_len[ph] / 2) hold_req = 1'b1;
                send_request(random_request());
            end
        end

        settle();
        if (model.errors == 0 && model.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tmb_pkg.sv
rtl/tmb_ctrl.sv
rtl/tmb_dpath.sv
rtl/multi_mode_countdown_timer_bank_top.sv
sim/tb.sv
